// File: hw/rtl/servo_angle_ramp_unit_defines.svh
// Assertion macros shared by the servo angle ramp RTL.
`ifndef SERVO_ANGLE_RAMP_UNIT_DEFINES_SVH
`define SERVO_ANGLE_RAMP_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SAR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("servo ramp check failed");
`define SAR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("servo ramp check failed");
`else
`define SAR_ASSERT_IMP(lbl, ante, cons)
`define SAR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/sar_pkg.sv
// Types, constants and helper functions of the servo angle ramp.
package sar_pkg;

	localparam int ANG_W = 11;
	typedef logic signed [ANG_W-1:0] ang_t;

	localparam logic [7:0]  ANGLE_LIMIT  = 8'd180;
	localparam logic [7:0]  RESET_ANGLE  = 8'd70;
	localparam logic [7:0]  MIN_STEP     = 8'd3;
	localparam logic [16:0] HOME_HOLD_MS = 17'd500;
	localparam logic [21:0] DUTY_BASE_NS = 22'd500000;
	localparam logic [21:0] DUTY_PER_DEG = 22'd11111;

	typedef enum logic {
		OP_MOVE = 1'b0,
		OP_HOME = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		REG_MIN_ANGLE  = 3'd0,
		REG_MAX_ANGLE  = 3'd1,
		REG_STEP_ANGLE = 3'd2,
		REG_STEP_DELAY = 3'd3,
		REG_HOME_ANGLE = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  min_angle;
		logic [7:0]  max_angle;
		logic [7:0]  step_angle;
		logic [15:0] step_delay_ms;
		logic [7:0]  home_angle;
	} cfg_t;

	typedef struct packed {
		ang_t a;
		ang_t b;
		logic sub;
	} alu_req_t;

	typedef struct packed {
		ang_t res;
		logic neg;
		logic zero;
	} alu_rsp_t;

	typedef struct packed {
		logic        valid;
		ang_t        angle;
		logic [16:0] hold;
		logic        last;
	} emit_t;

	// Low limit first, then high limit on the original value: high wins where both apply.
	function automatic logic [7:0] clamp_angle(ang_t a, logic [7:0] lo, logic [7:0] hi);
		ang_t s;
		s = a;
		if (a < ang_t'({3'b000, lo})) s = ang_t'({3'b000, lo});
		if (a > ang_t'({3'b000, hi})) s = ang_t'({3'b000, hi});
		return s[7:0];
	endfunction

endpackage

// File: hw/rtl/sar_cfg_regs.sv
// Configuration register file of the servo angle ramp.
module sar_cfg_regs
	import sar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data,
	output cfg_t        cfg
);

	logic [7:0]  min_q, max_q, step_q, home_q;
	logic [15:0] delay_q;
	logic [7:0]  sat_val;

	assign sat_val = (wr_data[7:0] > ANGLE_LIMIT) ? ANGLE_LIMIT : wr_data[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= 8'd0;
			max_q   <= ANGLE_LIMIT;
			step_q  <= 8'd5;
			delay_q <= 16'd100;
			home_q  <= RESET_ANGLE;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_MIN_ANGLE:  min_q   <= sat_val;
				REG_MAX_ANGLE:  max_q   <= sat_val;
				REG_STEP_ANGLE: step_q  <= wr_data[7:0];
				REG_STEP_DELAY: delay_q <= wr_data;
				REG_HOME_ANGLE: home_q  <= sat_val;
				default: ;
			endcase
		end
	end

	// Hold the raw step; raise it to the minimum on the way out.
	assign cfg.min_angle     = min_q;
	assign cfg.max_angle     = max_q;
	assign cfg.step_angle    = (step_q < MIN_STEP) ? MIN_STEP : step_q;
	assign cfg.step_delay_ms = delay_q;
	assign cfg.home_angle    = home_q;

endmodule

// File: hw/rtl/sar_alu.sv
// Shared add, subtract and compare unit of the servo angle ramp.
module sar_alu
	import sar_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	ang_t b_x;

	assign b_x      = req.sub ? ~req.b : req.b;
	assign rsp.res  = req.a + b_x + ang_t'({{(ANG_W-1){1'b0}}, req.sub});
	assign rsp.neg  = rsp.res[ANG_W-1];
	assign rsp.zero = (rsp.res == '0);

endmodule

// File: hw/rtl/sar_out_stage.sv
// Result register of the servo angle ramp: final clamp and duty calculation.
module sar_out_stage
	import sar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  emit_t       emit,
	input  logic [7:0]  lo,
	input  logic [7:0]  hi,
	output logic        free,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [21:0] duty_ns,
	output logic [7:0]  commanded_angle,
	output logic [16:0] hold_ms,
	output logic        last
);

	logic        valid_q;
	logic [21:0] duty_q;
	logic [7:0]  angle_q;
	logic [16:0] hold_q;
	logic        last_q;
	logic [7:0]  angle_c;

	assign free    = !valid_q || out_ready;
	assign angle_c = clamp_angle(emit.angle, lo, hi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && emit.valid) begin
			angle_q <= angle_c;
			duty_q  <= DUTY_BASE_NS + ({14'd0, angle_c} * DUTY_PER_DEG);
			hold_q  <= emit.hold;
			last_q  <= emit.last;
		end
	end

	assign out_valid       = valid_q;
	assign duty_ns         = duty_q;
	assign commanded_angle = angle_q;
	assign hold_ms         = hold_q;
	assign last            = last_q;

endmodule

// File: hw/rtl/servo_angle_ramp_unit.sv
// Top level of the servo angle ramp: sequencer around one shared adder.
// A move request clamps its target to [min_angle, max_angle] and walks the
// stored angle towards it in steps of step_angle (at least 3), giving one
// result per step with duty_ns = 500000 + 11111 * angle. Downward moves go
// one step past the target and then correct up to it; the last result of a
// move holds twice step_delay_ms. A move to the current angle gives nothing.
// A home request drives home-1 then home, each held 500 ms. A move runs
// the setup states match and direction, then an add and a compare state
// on the one shared adder per step result, and a fix state for the
// correcting step; an upward ramp first tries a step past the target in
// the compare state and drops it. The largest move gives 62 results. A
// home request runs the states home0 and home1. Each result state waits
// while the result register waits on out_ready. The next request is taken
// only once the sequencer is back in idle; the last result may still sit
// in the result register then. Configuration writes are always taken
// (cfg_ready is tied high); make them only while idle.
`include "servo_angle_ramp_unit_defines.svh"
module servo_angle_ramp_unit
	import sar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic signed [9:0] target_angle,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [21:0] duty_ns,
	output logic [7:0]  commanded_angle,
	output logic [16:0] hold_ms,
	output logic        last
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_DIR,
		S_ADD,
		S_TEST,
		S_FIX,
		S_HOME0,
		S_HOME1
	} state_t;

	state_t     state_q;
	ang_t       cur_q;    // walking angle; the stored servo angle between requests
	ang_t       tgt_q;    // raw target of the current move
	ang_t       nxt_q;    // candidate angle of the next step
	logic [7:0] dest_q;   // clamped target
	logic       down_q;

	cfg_t       cfg;
	alu_req_t   alu_req;
	alu_rsp_t   alu_rsp;
	emit_t      emit;
	logic       out_free;
	logic       emit_take;
	logic       up_fits;
	ang_t       dest_x;
	ang_t       step_x;
	logic [16:0] hold_step, hold_last;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);

	sar_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	sar_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	sar_out_stage u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.emit            (emit),
		.lo              (cfg.min_angle),
		.hi              (cfg.max_angle),
		.free            (out_free),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.duty_ns         (duty_ns),
		.commanded_angle (commanded_angle),
		.hold_ms         (hold_ms),
		.last            (last)
	);

	assign dest_x    = ang_t'({3'b000, dest_q});
	assign step_x    = ang_t'({3'b000, cfg.step_angle});
	assign hold_step = {1'b0, cfg.step_delay_ms};
	assign hold_last = {cfg.step_delay_ms, 1'b0};
	// Upward: the candidate step stays at or below the target.
	assign up_fits   = alu_rsp.neg || alu_rsp.zero;
	assign emit_take = emit.valid && out_free;

	// Steer the shared unit and form the result for the current state.
	always_comb begin
		alu_req = '{a: cur_q, b: dest_x, sub: 1'b1};
		emit    = '{valid: 1'b0, angle: cur_q, hold: hold_step, last: 1'b0};
		case (state_q)
			S_MATCH: begin
				alu_req.b = tgt_q;
			end
			S_DIR: begin
				alu_req.b = dest_x;
			end
			S_ADD: begin
				alu_req.b   = step_x;
				alu_req.sub = down_q;
			end
			S_TEST: begin
				alu_req.a  = nxt_q;
				emit.valid = down_q || up_fits;
				emit.angle = nxt_q;
				emit.last  = !down_q && alu_rsp.zero;
				emit.hold  = (!down_q && alu_rsp.zero) ? hold_last : hold_step;
			end
			S_FIX: begin
				emit.valid = 1'b1;
				emit.angle = dest_x;
				emit.hold  = hold_last;
				emit.last  = 1'b1;
			end
			S_HOME0: begin
				alu_req.b  = ang_t'(1);
				emit.valid = 1'b1;
				emit.angle = alu_rsp.res;
				emit.hold  = HOME_HOLD_MS;
			end
			S_HOME1: begin
				emit.valid = 1'b1;
				emit.hold  = HOME_HOLD_MS;
				emit.last  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q   <= ang_t'({3'b000, RESET_ANGLE});
			tgt_q   <= '0;
			nxt_q   <= '0;
			dest_q  <= '0;
			down_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (op_t'(operation) == OP_HOME) begin
							cur_q   <= ang_t'({3'b000, clamp_angle(
								ang_t'({3'b000, cfg.home_angle}),
								cfg.min_angle, cfg.max_angle)});
							state_q <= S_HOME0;
						end else begin
							tgt_q   <= {target_angle[9], target_angle};
							state_q <= S_MATCH;
						end
					end
				end
				S_MATCH: begin
					// drop a move to the current angle
					if (alu_rsp.zero) begin
						state_q <= S_IDLE;
					end else begin
						dest_q  <= clamp_angle(tgt_q, cfg.min_angle, cfg.max_angle);
						state_q <= S_DIR;
					end
				end
				S_DIR: begin
					if (alu_rsp.zero) begin
						state_q <= S_IDLE;
					end else begin
						down_q  <= !alu_rsp.neg;
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					nxt_q   <= alu_rsp.res;
					state_q <= S_TEST;
				end
				S_TEST: begin
					if (down_q) begin
						// keep stepping down while at or above the target, then correct
						if (emit_take) begin
							cur_q   <= nxt_q;
							state_q <= alu_rsp.neg ? S_FIX : S_ADD;
						end
					end else if (up_fits) begin
						if (emit_take) begin
							cur_q   <= nxt_q;
							state_q <= alu_rsp.zero ? S_IDLE : S_ADD;
						end
					end else begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					if (emit_take) begin
						cur_q   <= dest_x;
						state_q <= S_IDLE;
					end
				end
				S_HOME0: begin
					if (emit_take) state_q <= S_HOME1;
				end
				S_HOME1: begin
					if (emit_take) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The stored angle is a legal servo angle whenever no request is in work.
	`SAR_ASSERT_IMP(a_idle_angle_legal, state_q == S_IDLE, cur_q >= 0 && cur_q <= ang_t'({3'b000, ANGLE_LIMIT}))
	// A result flagged last closes the request.
	`SAR_ASSERT_NXT(a_last_ends_request, emit_take && emit.last, state_q == S_IDLE)
	// A home request always produces its first result state next.
	`SAR_ASSERT_NXT(a_home_starts, in_valid && in_ready && operation == OP_HOME, state_q == S_HOME0)
	// Downward steps never carry the last flag.
	`SAR_ASSERT_IMP(a_down_not_last, state_q == S_TEST && down_q && emit.valid, !emit.last)

endmodule

// File: verif/servo_angle_ramp_unit_checker.sv
// Scoreboard for the servo angle ramp: tracks settings and angle, predicts and compares results.
`timescale 1ns / 1ps
module servo_angle_ramp_unit_checker
	import sar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        operation,
	input  logic signed [9:0] target_angle,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [21:0] duty_ns,
	input  logic [7:0]  commanded_angle,
	input  logic [16:0] hold_ms,
	input  logic        last,
	output int          fail_count,
	output int          pending
);

	typedef struct {
		logic [21:0] duty;
		logic [7:0]  angle;
		logic [16:0] hold;
		logic        fin;
	} step_res_t;

	step_res_t   step_q[$];
	step_res_t   want;
	logic [7:0]  lim_lo;
	logic [7:0]  lim_hi;
	logic [7:0]  stride;
	logic [15:0] dwell;
	logic [7:0]  home_pos;
	int          pos;

	task automatic report(string what, longint got, longint exp_v);
		if (fail_count < 200)
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, exp_v);
		fail_count++;
	endtask

	// low limit first, high limit tested on the original value
	function automatic int bound(int a);
		int s;
		s = a;
		if (a < int'(lim_lo)) s = int'(lim_lo);
		if (a > int'(lim_hi)) s = int'(lim_hi);
		return s;
	endfunction

	function automatic logic [7:0] sat_deg(logic [15:0] v);
		return (v[7:0] > ANGLE_LIMIT) ? ANGLE_LIMIT : v[7:0];
	endfunction

	function automatic void queue_step(int a, logic [16:0] h, logic fin);
		step_res_t r;
		int c;
		c = bound(a);
		r.duty  = DUTY_BASE_NS + DUTY_PER_DEG * 22'(c);
		r.angle = 8'(c);
		r.hold  = h;
		r.fin   = fin;
		step_q.push_back(r);
	endfunction

	task automatic predict_request(logic op, logic signed [9:0] tgt_raw);
		int tgt, dest, s, cur, count, delta, n;
		int path[64];
		n = 0;
		tgt = int'(tgt_raw);
		if (op == OP_HOME) begin
			pos = bound(int'(home_pos));
			queue_step(pos - 1, HOME_HOLD_MS, 1'b0);
			queue_step(pos, HOME_HOLD_MS, 1'b1);
			return;
		end
		// raw target already at the stored angle: nothing moves
		if (tgt == pos)
			return;
		dest = bound(tgt);
		s = (stride < MIN_STEP) ? int'(MIN_STEP) : int'(stride);
		cur = pos;
		// downward ramps take one extra step past the target
		if (cur > dest) begin
			count = (cur - dest) / s + 1;
			delta = -s;
		end else begin
			count = (dest - cur) / s;
			delta = s;
		end
		while (count > 0) begin
			count--;
			cur += delta;
			path[n] = cur;
			n++;
		end
		if (cur != dest) begin
			path[n] = dest;
			n++;
		end
		pos = dest;
		for (int k = 0; k < n; k++)
			queue_step(path[k], (k == n - 1) ? {dwell, 1'b0} : {1'b0, dwell}, k == n - 1);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_lo     = 8'd0;
			lim_hi     = ANGLE_LIMIT;
			stride     = 8'd5;
			dwell      = 16'd100;
			home_pos   = RESET_ANGLE;
			pos        = int'(RESET_ANGLE);
			fail_count = 0;
			pending    = 0;
			step_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MIN_ANGLE:  lim_lo = sat_deg(cfg_data);
					REG_MAX_ANGLE:  lim_hi = sat_deg(cfg_data);
					REG_STEP_ANGLE: stride = cfg_data[7:0];
					REG_STEP_DELAY: dwell = cfg_data;
					REG_HOME_ANGLE: home_pos = sat_deg(cfg_data);
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (step_q.size() == 0) begin
					report("unexpected result, angle", commanded_angle, -1);
				end else begin
					want = step_q.pop_front();
					if (duty_ns !== want.duty)
						report("duty_ns", duty_ns, want.duty);
					if (commanded_angle !== want.angle)
						report("commanded_angle", commanded_angle, want.angle);
					if (hold_ms !== want.hold)
						report("hold_ms", hold_ms, want.hold);
					if (last !== want.fin)
						report("last", last, want.fin);
				end
			end
			if (in_valid && in_ready)
				predict_request(operation, target_angle);
			pending = step_q.size();
		end
	end

endmodule

// File: verif/servo_angle_ramp_unit_tb.sv
// Testbench top for the servo angle ramp: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module servo_angle_ramp_unit_tb;
	import sar_pkg::*;

	// quiet cycles tolerated: longest stall plus a full ramp, with margin
	localparam int WATCHDOG_LIMIT = 1000;
	// cycles to let a no-result request finish before touching registers
	localparam int IDLE_PAUSE = 10;
	// settling time at the end, above the slowest ramp
	localparam int END_WAIT = 150;
	localparam logic [2:0] REG_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] REG_UNUSED_LAST  = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic operation;
	logic signed [9:0] target_angle;
	logic out_valid;
	logic out_ready;
	logic [21:0] duty_ns;
	logic [7:0] commanded_angle;
	logic [16:0] hold_ms;
	logic last;

	int fail_count;
	int pending;
	int quiet_cycles = 0;
	// set for whole phases in which neither side pauses
	logic no_idle = 1'b0;
	int last_tgt = 0;

	always #6 clk = ~clk;

	servo_angle_ramp_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.target_angle    (target_angle),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.duty_ns         (duty_ns),
		.commanded_angle (commanded_angle),
		.hold_ms         (hold_ms),
		.last            (last)
	);

	servo_angle_ramp_unit_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.target_angle    (target_angle),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.duty_ns         (duty_ns),
		.commanded_angle (commanded_angle),
		.hold_ms         (hold_ms),
		.last            (last),
		.fail_count      (fail_count),
		.pending         (pending)
	);

	// Mostly back-to-back or short pauses, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle)
			return 0;
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Present one request and hold it until taken. Valid is lowered only when
	// a pause precedes this request, so back-to-back requests keep it high.
	task automatic push_request(op_t op, int tgt);
		int n;
		n = gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		target_angle <= 10'(tgt);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		if (op == OP_MOVE)
			last_tgt = tgt;
	endtask

	// One register write; the caller drops cfg_valid after its last write.
	task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop the request line, drain every expected result, then let a
	// request that gives no result run out before registers change.
	task automatic quiesce();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (IDLE_PAUSE) @(negedge clk);
	endtask

	// Angle register value: usually inside a window, sometimes anywhere,
	// sometimes a full 16-bit word to exercise saturation and upper bits.
	function automatic logic [15:0] pick_angle(int lo, int hi);
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 16'($urandom_range(lo, hi));
		if (r < 80)
			return 16'($urandom_range(0, 180));
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic rand_config();
		int r;
		cfg_write(REG_MIN_ANGLE, pick_angle(0, 30));
		cfg_write(REG_MAX_ANGLE, pick_angle(150, 180));
		r = $urandom_range(0, 99);
		if (r < 50)
			cfg_write(REG_STEP_ANGLE, 16'($urandom_range(3, 15)));
		else if (r < 80)
			cfg_write(REG_STEP_ANGLE, 16'($urandom_range(0, 40)));
		else
			cfg_write(REG_STEP_ANGLE, 16'($urandom_range(0, 65535)));
		r = $urandom_range(0, 99);
		if (r < 20)
			cfg_write(REG_STEP_DELAY, 16'd0);
		else if (r < 40)
			cfg_write(REG_STEP_DELAY, 16'hFFFF);
		else
			cfg_write(REG_STEP_DELAY, 16'($urandom_range(0, 65535)));
		cfg_write(REG_HOME_ANGLE, pick_angle(40, 100));
		// an unmapped index must leave every setting alone
		if ($urandom_range(0, 1))
			cfg_write(3'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
				16'($urandom_range(0, 65535)));
		cfg_valid <= 1'b0;
	endtask

	// Random requests: mostly moves near the servo range, some repeats of
	// the previous target (often a move to the current angle), some home
	// requests and some targets across the whole signed field.
	task automatic random_requests(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				push_request(OP_HOME, int'($urandom_range(0, 1023)) - 512);
			else if (r < 20)
				push_request(OP_MOVE, last_tgt);
			else if (r < 80)
				push_request(OP_MOVE, int'($urandom_range(0, 210)) - 10);
			else
				push_request(OP_MOVE, int'($urandom_range(0, 1023)) - 512);
		end
	endtask

	// Receiver: random stalls of mixed length, none in no-idle phases.
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
			end else if (!no_idle && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				hold_left = gap_len();
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: count cycles in which no channel moves anything.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		operation    = OP_MOVE;
		target_angle = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: limits 0..180, step 5, 100 ms, home 70.
		push_request(OP_MOVE, 70);    // already there: silent
		push_request(OP_MOVE, 511);   // clamps to 180, lands exactly
		push_request(OP_MOVE, -512);  // clamps to 0, overshoots below zero
		push_request(OP_MOVE, 0);     // raw target equals angle: silent
		push_request(OP_HOME, 0);
		push_request(OP_MOVE, 73);    // short upward move, correcting step only
		push_request(OP_MOVE, 180);
		push_request(OP_MOVE, 181);   // clamps onto the current angle: silent
		push_request(OP_MOVE, -1);

		// Crossed limits (high wins where both apply), step below the minimum, longest delay,
		// upper data bits ignored on an angle register.
		quiesce();
		cfg_write(REG_MIN_ANGLE, 16'h1214);
		cfg_write(REG_MAX_ANGLE, 16'd10);
		cfg_write(REG_STEP_ANGLE, 16'd0);
		cfg_write(REG_STEP_DELAY, 16'hFFFF);
		cfg_write(REG_HOME_ANGLE, 16'd0);
		cfg_write(REG_UNUSED_FIRST, 16'h5A5A);
		cfg_valid <= 1'b0;
		push_request(OP_MOVE, 50);
		push_request(OP_HOME, -512);
		push_request(OP_MOVE, 300);
		push_request(OP_MOVE, -300);

		// Full range, step 180, zero delay, home saturating to 180.
		quiesce();
		cfg_write(REG_MIN_ANGLE, 16'd0);
		cfg_write(REG_MAX_ANGLE, 16'd180);
		cfg_write(REG_STEP_ANGLE, 16'd180);
		cfg_write(REG_STEP_DELAY, 16'd0);
		cfg_write(REG_HOME_ANGLE, 16'hFFFF);
		cfg_valid <= 1'b0;
		push_request(OP_MOVE, 180);
		push_request(OP_MOVE, 0);
		push_request(OP_HOME, 511);
		push_request(OP_MOVE, 1);
		push_request(OP_MOVE, 511);

		// Smallest step over the full range: the longest ramps.
		quiesce();
		cfg_write(REG_STEP_ANGLE, 16'd3);
		cfg_write(REG_STEP_DELAY, 16'd1);
		cfg_write(REG_HOME_ANGLE, 16'd1);
		cfg_valid <= 1'b0;
		push_request(OP_MOVE, 180);
		push_request(OP_MOVE, 0);
		push_request(OP_HOME, 0);

		// Limits crossed at the extremes, step 255 with deep overshoot.
		quiesce();
		cfg_write(REG_MIN_ANGLE, 16'd180);
		cfg_write(REG_MAX_ANGLE, 16'd0);
		cfg_write(REG_STEP_ANGLE, 16'd255);
		cfg_write(REG_STEP_DELAY, 16'd300);
		cfg_write(REG_HOME_ANGLE, 16'd90);
		cfg_write(REG_UNUSED_LAST, 16'hFFFF);
		cfg_valid <= 1'b0;
		push_request(OP_MOVE, 90);
		push_request(OP_HOME, 0);

		// Random phases, each under fresh settings; one runs without pauses.
		for (int ph = 0; ph < 6; ph++) begin
			quiesce();
			no_idle = (ph == 2);
			rand_config();
			random_requests(80);
		end

		// Drain, then give the block time to show any stray result.
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (END_WAIT) @(negedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
